FILE: rtl/round_robin_task_slot_scheduler_assert.svh
// Assertion macros for the task slot scheduler checker.
`ifndef ROUND_ROBIN_TASK_SLOT_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TASK_SLOT_SCHEDULER_ASSERT_SVH

// Generic check, sampled on clk and masked while rst_n is low.
`define RRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A pending word holds its valid until it is taken.
`define RRTS_ASSERT_HOLD(lbl, vld, rdy, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> vld) \
    else $error(msg);

`endif

FILE: rtl/rrts_pkg.sv
// Shared constants and control types of the task slot scheduler.
`timescale 1ns / 1ps
package rrts_pkg;

  // Fixed field widths
  localparam int PID_W  = 5;
  localparam int OP_W   = 3;
  localparam int STS_W  = 2;
  localparam int WORD_W = 32;

  // Slot run states
  localparam logic [1:0] SLOT_FREE   = 2'd0;
  localparam logic [1:0] SLOT_IDLE   = 2'd1;
  localparam logic [1:0] SLOT_ACTIVE = 2'd2;
  localparam logic [1:0] SLOT_PARKED = 2'd3;

  // Event codes
  localparam logic [OP_W-1:0] OP_CREATE_FIRST = 3'd0;
  localparam logic [OP_W-1:0] OP_SPAWN        = 3'd1;
  localparam logic [OP_W-1:0] OP_FORK         = 3'd2;
  localparam logic [OP_W-1:0] OP_KILL         = 3'd3;
  localparam logic [OP_W-1:0] OP_WAIT_CHILD   = 3'd4;
  localparam logic [OP_W-1:0] OP_YIELD        = 3'd5;

  // Result status codes
  localparam logic [STS_W-1:0] ST_OK            = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL          = 2'd1;
  localparam logic [STS_W-1:0] ST_BAD_TARGET    = 2'd2;
  localparam logic [STS_W-1:0] ST_NONE_RUNNABLE = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic rd_issue;
    logic exec;
    logic yield;
    logic ww_issue;
    logic load_out;
  } rrts_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic yield_req;
  } rrts_sts_t;

endpackage

FILE: rtl/rrts_ifs.sv
// Event and result channel interfaces of the task slot scheduler.
`timescale 1ns / 1ps
interface rrts_in_if import rrts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [PID_W-1:0]  target_pid;
  logic [WORD_W-1:0] exit_value;
  logic              link_parent;

  modport source (output valid, output operation, output target_pid, output exit_value,
                  output link_parent, input ready);
  modport sink   (input valid, input operation, input target_pid, input exit_value,
                  input link_parent, output ready);
endinterface

interface rrts_out_if import rrts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STS_W-1:0]  status;
  logic [PID_W-1:0]  result_pid;
  logic [PID_W-1:0]  current_pid;
  logic [WORD_W-1:0] wait_word;

  modport source (output valid, output status, output result_pid, output current_pid,
                  output wait_word, input ready);
  modport sink   (input valid, input status, input result_pid, input current_pid,
                  input wait_word, output ready);
endinterface

FILE: rtl/round_robin_task_slot_scheduler.sv
// Top level of the round-robin task slot scheduler.
// Usage:
//   in_ch takes one scheduler event per word (create first, spawn, fork, kill,
//   wait child, yield) with its target pid, exit value and link flag.
//   out_ch returns exactly one word per event: status, pid chosen or created,
//   running pid afterwards and the running task's wait word.
//   Both channels move a word when valid and ready are high at a clock edge.
//   Events are handled one at a time by a sequencer: read the wait word
//   memory, update the tables, optionally run the round-robin pick, then read
//   the running task's wait word, and load the result word into the output
//   register. The pick runs only when the event ends in one (yield, wait
//   child, kill of the running task).
//   in_ch.ready comes back in the same cycle the result word appears, so a
//   new event is taken only once the last one is through the sequencer.
//   The result sits in an output register: a new event is taken while it
//   waits, and only the load of the next result stalls behind a held word.
//   Synchronous reset (rst_n low) frees every slot and leaves no task
//   running; no clearing pass is needed, the tables are ready at once.
`timescale 1ns / 1ps
module round_robin_task_slot_scheduler import rrts_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  rrts_in_if.sink    in_ch,
  rrts_out_if.source out_ch
);

  rrts_cmd_t cmd;
  rrts_sts_t sts;

  // Sequencer
  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Tables and result
  rrts_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_ch.operation),
    .in_target_pid   (in_ch.target_pid),
    .in_exit_value   (in_ch.exit_value),
    .in_link_parent  (in_ch.link_parent),
    .out_status      (out_ch.status),
    .out_result_pid  (out_ch.result_pid),
    .out_current_pid (out_ch.current_pid),
    .out_wait_word   (out_ch.wait_word)
  );

endmodule

FILE: rtl/rrts_ctrl.sv
// Sequencer of the task slot scheduler: steps one event through the datapath.
`timescale 1ns / 1ps
module rrts_ctrl import rrts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  rrts_sts_t sts,
  output rrts_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_YIELD = 3'd3;
  localparam logic [2:0] S_WWRD  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.yield_req ? S_YIELD : S_WWRD;
      end
      S_YIELD: begin
        cmd.yield = 1'b1;
        state_nxt = S_WWRD;
      end
      S_WWRD: begin
        cmd.ww_issue = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to drain
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output word valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/rrts_dp.sv
// Datapath of the task slot scheduler: slot tables, wait word memory, scans, result.
`timescale 1ns / 1ps
module rrts_dp import rrts_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rrts_cmd_t         cmd,
  output rrts_sts_t         sts,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [PID_W-1:0]  in_target_pid,
  input  logic [WORD_W-1:0] in_exit_value,
  input  logic              in_link_parent,
  output logic [STS_W-1:0]  out_status,
  output logic [PID_W-1:0]  out_result_pid,
  output logic [PID_W-1:0]  out_current_pid,
  output logic [WORD_W-1:0] out_wait_word
);

  localparam int SW = $clog2(NUM_SLOTS);
  typedef logic [SW-1:0] slot_t;

  // Lowest set bit of a slot vector
  function automatic slot_t lowest_idx(logic [NUM_SLOTS-1:0] v);
    slot_t r;
    int    i;
    r = '0;
    for (i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) r = slot_t'(i);
    end
    return r;
  endfunction

  // Slot index to pid
  function automatic logic [PID_W-1:0] to_pid(slot_t s);
    return PID_W'({1'b0, s} + 1'b1);
  endfunction

  // Captured event
  logic [OP_W-1:0]   op_r;
  logic [PID_W-1:0]  tgt_r;
  logic [WORD_W-1:0] exit_r;
  logic              link_r;

  // Slot tables and running slot
  logic [1:0]        run_st_r  [NUM_SLOTS];
  slot_t             par_idx_r [NUM_SLOTS];
  logic              par_vld_r [NUM_SLOTS];
  logic [WORD_W-1:0] ww_mem    [NUM_SLOTS];
  logic [WORD_W-1:0] rd_data_r;
  slot_t             cur_r;
  logic              cur_vld_r;

  // Result being built and the output word
  logic [STS_W-1:0]  res_status_r;
  logic [PID_W-1:0]  res_pid_r;
  logic [STS_W-1:0]  out_status_r;
  logic [PID_W-1:0]  out_result_r;
  logic [PID_W-1:0]  out_current_r;
  logic [WORD_W-1:0] out_ww_r;

  logic [NUM_SLOTS-1:0] free_vec, run_vec, above_vec;
  logic                 free_any, pick_any, hi_any;
  slot_t                free_idx, pick_idx, base_idx;
  slot_t                tgt_idx, par_of_tgt, raddr, waddr;
  logic                 pvld_of_tgt, tgt_in_range, tgt_live;
  logic                 kill_ok, wake, wait_ok, victim_running;
  logic                 alloc_op, alloc_go;
  logic                 mem_we;
  logic [WORD_W-1:0]    wdata;

  // Capture the accepted event
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      tgt_r  <= in_target_pid;
      exit_r <= in_exit_value;
      link_r <= in_link_parent;
    end
  end

  // Per-slot flags
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      free_vec[i]  = (run_st_r[i] == SLOT_FREE);
      run_vec[i]   = (run_st_r[i] == SLOT_IDLE) || (run_st_r[i] == SLOT_ACTIVE);
      above_vec[i] = (slot_t'(i) > base_idx) && run_vec[i];
    end
  end

  // Allocation and round-robin pick
  assign free_any = |free_vec;
  assign free_idx = lowest_idx(free_vec);
  assign base_idx = cur_vld_r ? cur_r : slot_t'(NUM_SLOTS - 1);
  assign hi_any   = |above_vec;
  assign pick_any = |run_vec;
  assign pick_idx = hi_any ? lowest_idx(above_vec) : lowest_idx(run_vec);

  // Target checks
  assign tgt_in_range   = (tgt_r != '0) && (32'(tgt_r) <= 32'(NUM_SLOTS));
  assign tgt_idx        = slot_t'(tgt_r - PID_W'(1));
  assign tgt_live       = tgt_in_range && (run_st_r[tgt_idx] != SLOT_FREE);
  assign par_of_tgt     = par_idx_r[tgt_idx];
  assign pvld_of_tgt    = par_vld_r[tgt_idx];
  assign victim_running = cur_vld_r && (cur_r == tgt_idx);

  assign kill_ok = tgt_live;
  assign wake    = kill_ok && pvld_of_tgt && (run_st_r[par_of_tgt] == SLOT_PARKED) &&
                   ((rd_data_r == 32'(tgt_r)) || (rd_data_r == '0));
  assign wait_ok = cur_vld_r &&
                   ((tgt_r == '0) || (tgt_live && pvld_of_tgt && (par_of_tgt == cur_r)));

  assign alloc_op = op_r inside {OP_CREATE_FIRST, OP_SPAWN, OP_FORK};
  assign alloc_go = alloc_op && free_any && !((op_r == OP_FORK) && !cur_vld_r);

  assign sts.yield_req = ((op_r == OP_KILL) && kill_ok && victim_running) ||
                         (op_r == OP_WAIT_CHILD) || (op_r == OP_YIELD);

  // Wait word memory: one write, one registered read
  assign raddr = (cmd.rd_issue && (op_r == OP_KILL)) ? par_of_tgt : cur_r;

  always_comb begin
    mem_we = 1'b0;
    waddr  = free_idx;
    wdata  = '0;
    if (cmd.exec) begin
      if (alloc_go) begin
        mem_we = 1'b1;
        wdata  = (op_r == OP_FORK) ? rd_data_r : '0;
      end else if ((op_r == OP_KILL) && wake) begin
        mem_we = 1'b1;
        waddr  = par_of_tgt;
        wdata  = exit_r;
      end else if ((op_r == OP_WAIT_CHILD) && wait_ok) begin
        mem_we = 1'b1;
        waddr  = cur_r;
        wdata  = 32'(tgt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ww_mem[waddr] <= wdata;
    end
    if (cmd.rd_issue || cmd.ww_issue) begin
      rd_data_r <= ww_mem[raddr];
    end
  end

  // Parent index: read only behind its valid bit
  always_ff @(posedge clk) begin
    if (cmd.exec && alloc_go) begin
      par_idx_r[free_idx] <= cur_r;
    end
  end

  // Run states, parent links, running slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        run_st_r[i]  <= SLOT_FREE;
        par_vld_r[i] <= 1'b0;
      end
      cur_r     <= '0;
      cur_vld_r <= 1'b0;
    end else if (cmd.exec) begin
      if (alloc_go) begin
        case (op_r)
          OP_CREATE_FIRST: begin
            run_st_r[free_idx]  <= SLOT_ACTIVE;
            par_vld_r[free_idx] <= 1'b0;
            cur_r               <= free_idx;
            cur_vld_r           <= 1'b1;
          end
          OP_SPAWN: begin
            run_st_r[free_idx]  <= SLOT_IDLE;
            par_vld_r[free_idx] <= link_r && cur_vld_r;
          end
          default: begin
            run_st_r[free_idx]  <= run_st_r[cur_r];
            par_vld_r[free_idx] <= 1'b1;
          end
        endcase
      end else if (op_r == OP_KILL) begin
        // wake first, so a self-linked victim still ends up free
        if (wake) begin
          run_st_r[par_of_tgt] <= SLOT_ACTIVE;
        end
        if (kill_ok) begin
          run_st_r[tgt_idx]  <= SLOT_FREE;
          par_vld_r[tgt_idx] <= 1'b0;
        end
      end else if ((op_r == OP_WAIT_CHILD) && wait_ok) begin
        run_st_r[cur_r] <= SLOT_PARKED;
      end
    end else if (cmd.yield) begin
      cur_r     <= pick_any ? pick_idx : '0;
      cur_vld_r <= pick_any;
    end
  end

  // Result status and pid
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r <= ST_OK;
      res_pid_r    <= '0;
      if (alloc_op) begin
        if ((op_r == OP_FORK) && !cur_vld_r) begin
          res_status_r <= ST_BAD_TARGET;
        end else if (!free_any) begin
          res_status_r <= ST_FULL;
        end else begin
          res_pid_r <= to_pid(free_idx);
        end
      end else if ((op_r == OP_KILL) && !kill_ok) begin
        res_status_r <= ST_BAD_TARGET;
      end else if ((op_r == OP_WAIT_CHILD) && !wait_ok) begin
        res_status_r <= ST_BAD_TARGET;
      end
    end else if (cmd.yield) begin
      if (pick_any) begin
        res_pid_r <= to_pid(pick_idx);
      end else begin
        res_pid_r    <= '0;
        res_status_r <= ST_NONE_RUNNABLE;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r  <= res_status_r;
      out_result_r  <= res_pid_r;
      out_current_r <= cur_vld_r ? to_pid(cur_r) : '0;
      out_ww_r      <= cur_vld_r ? rd_data_r : '0;
    end
  end

  assign out_status      = out_status_r;
  assign out_result_pid  = out_result_r;
  assign out_current_pid = out_current_r;
  assign out_wait_word   = out_ww_r;

endmodule

FILE: rtl/rrts_checker.sv
// Port-level checks of the task slot scheduler and their binding.
`timescale 1ns / 1ps
`include "round_robin_task_slot_scheduler_assert.svh"
module rrts_checker import rrts_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [STS_W-1:0] out_status,
  input logic [PID_W-1:0] out_result_pid,
  input logic [PID_W-1:0] out_current_pid
);

  // result word waits for the receiver
  `RRTS_ASSERT_HOLD(a_out_hold, out_valid, out_ready, "result word dropped while stalled")

  // one event in flight: ready drops after a take
  `RRTS_ASSERT(a_one_in_flight, (in_valid && in_ready) |=> !in_ready, "second event taken early")

  // nothing runnable leaves no running task
  `RRTS_ASSERT(a_none_runnable, (out_valid && (out_status == ST_NONE_RUNNABLE)) |-> ((out_result_pid == '0) && (out_current_pid == '0)), "idle result names a task")

  // a full table creates nothing
  `RRTS_ASSERT(a_full_no_pid, (out_valid && (out_status == ST_FULL)) |-> (out_result_pid == '0), "full table returned a pid")

endmodule

bind round_robin_task_slot_scheduler rrts_checker u_rrts_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_result_pid  (out_ch.result_pid),
  .out_current_pid (out_ch.current_pid)
);

FILE: bench/rrts_sched_checker.sv
// Scoreboard for the task slot scheduler: tracks the slot table and checks each result word.
`timescale 1ns / 1ps
module rrts_sched_checker import rrts_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [PID_W-1:0]     in_target_pid,
  input  logic [WORD_W-1:0]    in_exit_value,
  input  logic                 in_link_parent,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [STS_W-1:0]     out_status,
  input  logic [PID_W-1:0]     out_result_pid,
  input  logic [PID_W-1:0]     out_current_pid,
  input  logic [WORD_W-1:0]    out_wait_word,
  output int                   fail_count,
  output int                   outstanding,
  output int                   ok_count,
  output int                   full_count,
  output int                   bad_count,
  output int                   none_count,
  output int                   wake_count,
  output logic [NUM_SLOTS-1:0] live_mask,
  output logic [NUM_SLOTS-1:0] child_mask
);

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [PID_W-1:0]  result_pid;
    logic [PID_W-1:0]  current_pid;
    logic [WORD_W-1:0] wait_word;
  } sched_word_t;

  // Shadow of the slot table
  logic [1:0]        slot_state  [NUM_SLOTS];
  int unsigned       slot_parent [NUM_SLOTS];
  bit                slot_linked [NUM_SLOTS];
  logic [WORD_W-1:0] slot_wword  [NUM_SLOTS];
  int unsigned       run_slot;
  bit                run_valid;

  sched_word_t       pending_words[$];
  int                words_checked;

  function automatic void free_slot(input int unsigned s);
    slot_state[s]  = SLOT_FREE;
    slot_parent[s] = 0;
    slot_linked[s] = 1'b0;
    slot_wword[s]  = '0;
  endfunction

  // Round-robin pick after the running slot, the running slot itself last
  function automatic void rr_switch(inout sched_word_t w);
    int unsigned base;
    int unsigned s;
    bit          found;
    base  = run_valid ? run_slot : NUM_SLOTS - 1;
    found = 1'b0;
    for (int k = 1; k <= NUM_SLOTS && !found; k++) begin
      s = (base + k) % NUM_SLOTS;
      if (slot_state[s] == SLOT_IDLE || slot_state[s] == SLOT_ACTIVE) begin
        run_slot = s;
        found    = 1'b1;
      end
    end
    run_valid = found;
    if (found) begin
      w.result_pid = PID_W'(run_slot + 1);
    end else begin
      run_slot     = 0;
      w.result_pid = '0;
      w.status     = ST_NONE_RUNNABLE;
    end
  endfunction

  // Applies one event to the shadow table and returns the word it should produce
  function automatic sched_word_t apply_event(input logic [OP_W-1:0]   op,
                                              input logic [PID_W-1:0]  tgt,
                                              input logic [WORD_W-1:0] xv,
                                              input logic              lnk);
    sched_word_t w;
    int          f;
    int unsigned cur;
    int unsigned v;
    int unsigned p;
    bit          park_ok;
    bit          was_running;
    w   = '0;
    f   = -1;
    cur = run_slot;
    case (op)
      OP_CREATE_FIRST, OP_SPAWN, OP_FORK: begin
        for (int s = NUM_SLOTS - 1; s >= 0; s--)
          if (slot_state[s] == SLOT_FREE) f = s;
        if (op == OP_FORK && !run_valid) begin
          w.status = ST_BAD_TARGET;
        end else if (f < 0) begin
          w.status = ST_FULL;
        end else begin
          free_slot(f);
          if (op == OP_CREATE_FIRST) begin
            slot_state[f] = SLOT_ACTIVE;
            run_slot      = f;
            run_valid     = 1'b1;
          end else if (op == OP_SPAWN) begin
            slot_state[f] = SLOT_IDLE;
            if (lnk && run_valid) begin
              slot_parent[f] = cur;
              slot_linked[f] = 1'b1;
            end
          end else begin
            // fork inherits run state and wait word of the running task
            slot_state[f]  = slot_state[cur];
            slot_wword[f]  = slot_wword[cur];
            slot_parent[f] = cur;
            slot_linked[f] = 1'b1;
          end
          w.result_pid = PID_W'(f + 1);
        end
      end
      OP_KILL: begin
        if (tgt == 0 || tgt > NUM_SLOTS || slot_state[tgt - 1] == SLOT_FREE) begin
          w.status = ST_BAD_TARGET;
        end else begin
          v           = tgt - 1;
          was_running = run_valid && run_slot == v;
          // wake a parent parked on this child or on any child
          if (slot_linked[v]) begin
            p = slot_parent[v];
            if (slot_state[p] == SLOT_PARKED &&
                (slot_wword[p] == tgt || slot_wword[p] == 0)) begin
              slot_state[p] = SLOT_ACTIVE;
              slot_wword[p] = xv;
              wake_count++;
            end
          end
          free_slot(v);
          if (was_running) rr_switch(w);
        end
      end
      OP_WAIT_CHILD: begin
        park_ok = run_valid;
        if (park_ok && tgt != 0) begin
          if (tgt > NUM_SLOTS) begin
            park_ok = 1'b0;
          end else if (slot_state[tgt - 1] == SLOT_FREE || !slot_linked[tgt - 1] ||
                       slot_parent[tgt - 1] != cur) begin
            park_ok = 1'b0;
          end
        end
        if (park_ok) begin
          slot_state[cur] = SLOT_PARKED;
          slot_wword[cur] = WORD_W'(tgt);
        end else begin
          w.status = ST_BAD_TARGET;
        end
        rr_switch(w);
      end
      OP_YIELD: rr_switch(w);
      default: ;
    endcase
    if (run_valid) begin
      w.current_pid = PID_W'(run_slot + 1);
      w.wait_word   = slot_wword[run_slot];
    end
    return w;
  endfunction

  task automatic compare_field(input string fname, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("word %0d: %s expected %0h, got %0h", words_checked, fname, want, got);
    end
  endtask

  // Compare accepted results, then predict the accepted event
  always @(posedge clk) begin : track
    sched_word_t           want;
    logic [NUM_SLOTS-1:0]  live_next;
    logic [NUM_SLOTS-1:0]  kids_next;
    if (!rst_n) begin
      for (int s = 0; s < NUM_SLOTS; s++) free_slot(s);
      run_slot      = 0;
      run_valid     = 1'b0;
      pending_words.delete();
      words_checked = 0;
      fail_count    = 0;
      ok_count      = 0;
      full_count    = 0;
      bad_count     = 0;
      none_count    = 0;
      wake_count    = 0;
    end else begin
      if (out_valid && out_ready) begin
        words_checked++;
        if (pending_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("word %0d: result arrived with no event waiting", words_checked);
        end else begin
          want = pending_words.pop_front();
          compare_field("status", WORD_W'(want.status), WORD_W'(out_status));
          compare_field("result_pid", WORD_W'(want.result_pid), WORD_W'(out_result_pid));
          compare_field("current_pid", WORD_W'(want.current_pid), WORD_W'(out_current_pid));
          compare_field("wait_word", want.wait_word, out_wait_word);
        end
      end
      if (in_valid && in_ready) begin
        want = apply_event(in_operation, in_target_pid, in_exit_value, in_link_parent);
        pending_words.push_back(want);
        case (want.status)
          ST_OK:         ok_count++;
          ST_FULL:       full_count++;
          ST_BAD_TARGET: bad_count++;
          default:       none_count++;
        endcase
      end
    end
    // table hints for the stimulus side
    for (int s = 0; s < NUM_SLOTS; s++) begin
      live_next[s] = slot_state[s] != SLOT_FREE;
      kids_next[s] = live_next[s] && run_valid && slot_linked[s] && slot_parent[s] == run_slot;
    end
    live_mask   <= live_next;
    child_mask  <= kids_next;
    outstanding <= pending_words.size();
  end

endmodule

FILE: bench/tb.sv
// Top of the task slot scheduler bench: clock, reset, event stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import rrts_pkg::*;

  localparam int NUM_SLOTS    = 16;
  localparam int RANDOM_WORDS = 2060;
  localparam int CYCLE_LIMIT  = 300000;

  logic clk;
  logic rst_n;
  bit   calm;
  int   cycles = 0;

  int                   fail_count;
  int                   outstanding;
  int                   ok_count;
  int                   full_count;
  int                   bad_count;
  int                   none_count;
  int                   wake_count;
  logic [NUM_SLOTS-1:0] live_mask;
  logic [NUM_SLOTS-1:0] child_mask;

  rrts_in_if  in_ch ();
  rrts_out_if out_ch ();

  round_robin_task_slot_scheduler #(.NUM_SLOTS(NUM_SLOTS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rrts_sched_checker #(.NUM_SLOTS(NUM_SLOTS)) u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_operation    (in_ch.operation),
    .in_target_pid   (in_ch.target_pid),
    .in_exit_value   (in_ch.exit_value),
    .in_link_parent  (in_ch.link_parent),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_result_pid  (out_ch.result_pid),
    .out_current_pid (out_ch.current_pid),
    .out_wait_word   (out_ch.wait_word),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .ok_count        (ok_count),
    .full_count      (full_count),
    .bad_count       (bad_count),
    .none_count      (none_count),
    .wake_count      (wake_count),
    .live_mask       (live_mask),
    .child_mask      (child_mask)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 22);
    end
  end

  // Offers one event word, with random gaps ahead of it, and waits until taken
  task automatic post_event(input logic [OP_W-1:0] op, input logic [PID_W-1:0] tgt,
                            input logic [WORD_W-1:0] xv, input logic lnk);
    while (!calm && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.target_pid  <= tgt;
    in_ch.exit_value  <= xv;
    in_ch.link_parent <= lnk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Holds off the sender until every result is back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Random pid among the set bits of a slot mask, 0 if none
  function automatic logic [PID_W-1:0] pick_pid(input logic [NUM_SLOTS-1:0] mask);
    int unsigned      start;
    int unsigned      s;
    logic [PID_W-1:0] pid;
    pid   = '0;
    start = $urandom_range(NUM_SLOTS - 1);
    for (int k = 0; k < NUM_SLOTS; k++) begin
      s = (start + k) % NUM_SLOTS;
      if (mask[s] && pid == 0) pid = PID_W'(s + 1);
    end
    return pid;
  endfunction

  // Mostly meaningful events: kills aim at live tasks, waits at real children
  task automatic random_event(input int idx);
    logic [OP_W-1:0]   op;
    logic [PID_W-1:0]  tgt;
    logic [WORD_W-1:0] xv;
    logic              lnk;
    int unsigned       w;
    int unsigned       r;
    bit                cull;
    cull = ((idx / 200) % 3 == 2) || ($countones(live_mask) >= 14);
    w    = $urandom_range(99);
    r    = $urandom_range(99);
    tgt  = PID_W'($urandom_range(31));
    lnk  = $urandom_range(3) != 0;
    xv   = $urandom;
    case ($urandom_range(15))
      0: xv = '0;
      1: xv = '1;
      default: ;
    endcase
    if (w < 3) begin
      op = OP_W'($urandom_range(7, 6));
    end else if ((cull && w < 45) || (w >= 44 && w < 66)) begin
      op = OP_KILL;
      if (r < 70) tgt = pick_pid(live_mask);
      else if (r < 85) tgt = pick_pid(child_mask);
    end else if (w < 10) begin
      op = OP_CREATE_FIRST;
    end else if (w < 28) begin
      op = OP_SPAWN;
    end else if (w < 44) begin
      op = OP_FORK;
    end else if (w < 84) begin
      op = OP_WAIT_CHILD;
      if (r < 35) tgt = '0;
      else if (r < 80) tgt = pick_pid(child_mask);
    end else begin
      op = OP_YIELD;
    end
    post_event(op, tgt, xv, lnk);
  endtask

  initial begin
    rst_n             <= 1'b0;
    calm              <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_YIELD;
    in_ch.target_pid  <= '0;
    in_ch.exit_value  <= '0;
    in_ch.link_parent <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: nothing to run, fork, kill and wait have no target, unknown op codes
    post_event(OP_YIELD,      5'd0,  32'h0,         1'b0);
    post_event(OP_FORK,       5'd0,  32'h0,         1'b1);
    post_event(OP_KILL,       5'd0,  32'h0,         1'b0);
    post_event(OP_KILL,       5'd17, 32'h0,         1'b0);
    post_event(OP_KILL,       5'd31, 32'hFFFF_FFFF, 1'b1);
    post_event(OP_WAIT_CHILD, 5'd0,  32'h0,         1'b0);
    post_event(3'd6,          5'd3,  32'h1234_5678, 1'b1);
    post_event(3'd7,          5'd16, 32'h0,         1'b0);
    // Build a small family: pid1 with a linked pid2, an orphan pid3 and a fork pid4
    post_event(OP_CREATE_FIRST, 5'd0, 32'h0, 1'b0);
    post_event(OP_SPAWN,        5'd0, 32'h0, 1'b1);
    post_event(OP_SPAWN,        5'd0, 32'h0, 1'b0);
    post_event(OP_FORK,         5'd0, 32'h0, 1'b0);
    // Wait on a task that is not a child: refused, yet still switches
    post_event(OP_WAIT_CHILD, 5'd3, 32'h0, 1'b0);
    post_event(OP_YIELD,      5'd0, 32'h0, 1'b0);
    post_event(OP_KILL,       5'd5, 32'h0, 1'b0);
    // Kill the running orphan, then come back around to pid1
    post_event(OP_KILL,  5'd3, 32'h0, 1'b0);
    post_event(OP_YIELD, 5'd0, 32'h0, 1'b0);
    // pid1 parks on pid2; killing pid2 wakes it with the exit value
    post_event(OP_WAIT_CHILD, 5'd2, 32'h0,         1'b0);
    post_event(OP_KILL,       5'd2, 32'hFFFF_FFFF, 1'b0);
    // pid4 parks on any child, then that child dies
    post_event(OP_SPAWN,      5'd0,  32'h0,         1'b1);
    post_event(OP_WAIT_CHILD, 5'd0,  32'h0,         1'b0);
    post_event(OP_KILL,       5'd2,  32'h5A5A_A5A5, 1'b0);
    post_event(OP_KILL,       5'd16, 32'h0,         1'b0);
    // Kill everyone left: last one leaves nothing runnable
    post_event(OP_KILL,         5'd1,  32'h0, 1'b0);
    post_event(OP_KILL,         5'd4,  32'h0, 1'b0);
    post_event(OP_WAIT_CHILD,   5'd20, 32'h0, 1'b0);
    drain_results();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm <= (i >= 1200 && i < 1500);
      if (i == 1000) drain_results();
      random_event(i);
    end
    drain_results();
    repeat (20) @(posedge clk);

    $display("Covered %0d scheduler events: %0d ok, %0d table full, %0d bad target, %0d idle",
             ok_count + full_count + bad_count + none_count, ok_count, full_count, bad_count,
             none_count);
    $display("Parked parents woken by a child exit: %0d", wake_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
